### sv/skci_pkg.sv
// shared types, constants and microcode program of the stage kc interpolator
`default_nettype none

package skci_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // field widths
   localparam int STAGE_W = 16;
   localparam int KC_W    = 16;
   localparam int ENTRY_W = STAGE_W + KC_W;
   localparam int PROD_W  = 2 * KC_W;

   // divider
   localparam int DIV_STEPS = KC_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // stage 2.0 in signed q2.13
   localparam logic signed [STAGE_W-1:0] STAGE_TWO = 16'sd16384;

   // transaction opcodes
   localparam logic OPC_LOAD = 1'b0;
   localparam logic OPC_EVAL = 1'b1;

   // register indexes of the csr port
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_BARE_KC     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POST_KC     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_COUNT = 2'd2;
   localparam int PCOUNT_W = 5;

   // result source codes
   typedef enum logic [1:0] {
      SRC_INTERP = 2'd0,
      SRC_BARE   = 2'd1,
      SRC_POST   = 2'd2,
      SRC_CLAMP  = 2'd3
   } src_type;

   // datapath operations, one per control word
   typedef enum logic [3:0] {
      OP_NOP,
      OP_LATCH,
      OP_FIRST,
      OP_SCAN,
      OP_NOMATCH,
      OP_MUL,
      OP_PREP,
      OP_DIV,
      OP_FINISH,
      OP_EMIT
   } op_type;

   // branch conditions
   typedef enum logic [2:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_EVAL,
      C_SPECIAL,
      C_MATCH,
      C_MORE,
      C_DIV_MORE,
      C_OUT_FREE
   } cond_type;

   // program counter and step addresses
   localparam int PC_W = 4;
   localparam logic [PC_W-1:0] PC_IDLE    = 4'd0;
   localparam logic [PC_W-1:0] PC_FIRST   = 4'd1;
   localparam logic [PC_W-1:0] PC_SCAN    = 4'd2;
   localparam logic [PC_W-1:0] PC_NOMATCH = 4'd3;
   localparam logic [PC_W-1:0] PC_MUL     = 4'd4;
   localparam logic [PC_W-1:0] PC_PREP    = 4'd5;
   localparam logic [PC_W-1:0] PC_DIV     = 4'd6;
   localparam logic [PC_W-1:0] PC_FINISH  = 4'd7;
   localparam logic [PC_W-1:0] PC_EMIT    = 4'd8;

   // control word: jump wins over stay, otherwise fall through
   typedef struct packed {
      op_type            op;
      cond_type          jump;
      cond_type          stay;
      logic [PC_W-1:0]   target;
   } ucode_type;

   // status flags from the datapath to the sequencer
   typedef struct packed {
      logic eval_accept;
      logic special;
      logic match;
      logic more;
      logic div_more;
      logic out_free;
   } status_type;

   // microcode program
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      w = '{op: OP_NOP, jump: C_ALWAYS, stay: C_NEVER, target: PC_IDLE};
      unique case (pc)
         PC_IDLE:    w = '{op: OP_LATCH,   jump: C_NEVER,   stay: C_NO_EVAL,
                           target: PC_IDLE};
         PC_FIRST:   w = '{op: OP_FIRST,   jump: C_SPECIAL, stay: C_NEVER,
                           target: PC_EMIT};
         PC_SCAN:    w = '{op: OP_SCAN,    jump: C_MATCH,   stay: C_MORE,
                           target: PC_MUL};
         PC_NOMATCH: w = '{op: OP_NOMATCH, jump: C_ALWAYS,  stay: C_NEVER,
                           target: PC_EMIT};
         PC_MUL:     w = '{op: OP_MUL,     jump: C_NEVER,   stay: C_NEVER,
                           target: PC_IDLE};
         PC_PREP:    w = '{op: OP_PREP,    jump: C_NEVER,   stay: C_NEVER,
                           target: PC_IDLE};
         PC_DIV:     w = '{op: OP_DIV,     jump: C_NEVER,   stay: C_DIV_MORE,
                           target: PC_IDLE};
         PC_FINISH:  w = '{op: OP_FINISH,  jump: C_NEVER,   stay: C_NEVER,
                           target: PC_IDLE};
         PC_EMIT:    w = '{op: OP_EMIT,    jump: C_OUT_FREE, stay: C_ALWAYS,
                           target: PC_IDLE};
         default:    w = '{op: OP_NOP,     jump: C_ALWAYS,  stay: C_NEVER,
                           target: PC_IDLE};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

### sv/skci_ram.sv
// generic single write port ram with registered read
`default_nettype none

module skci_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### sv/skci_seq.sv
// microcode sequencer: step counter, control rom and branch logic
`default_nettype none

module skci_seq
   import skci_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire status_type status,
   output op_type          op
);

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   ucode_type       word;
   logic            jump_taken;
   logic            stay_taken;

   function automatic logic cond_eval(input cond_type c, input status_type st);
      logic r;
      r = 1'b0;
      unique case (c)
         C_NEVER:    r = 1'b0;
         C_ALWAYS:   r = 1'b1;
         C_NO_EVAL:  r = !st.eval_accept;
         C_SPECIAL:  r = st.special;
         C_MATCH:    r = st.match;
         C_MORE:     r = st.more;
         C_DIV_MORE: r = st.div_more;
         C_OUT_FREE: r = st.out_free;
         default:    r = 1'b0;
      endcase
      return r;
   endfunction

   // fetch and next step selection
   always_comb begin
      word       = ucode_rom(pc_ff);
      jump_taken = cond_eval(word.jump, status);
      stay_taken = cond_eval(word.stay, status);
      if (jump_taken) begin
         pc_in = word.target;
      end else if (stay_taken) begin
         pc_in = pc_ff;
      end else begin
         pc_in = pc_ff + PC_W'(1);
      end
   end

   // step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign op = word.op;

endmodule

`default_nettype wire

### sv/skci_dp.sv
// datapath: breakpoint table, segment scan, multiplier, serial divider, output register
`default_nettype none

module skci_dp
   import skci_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire op_type                     op,
   output status_type                      status,
   // transaction input
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic                       req_opcode,
   input  wire logic [3:0]                 req_entry_index,
   input  wire logic signed [STAGE_W-1:0]  req_entry_stage,
   input  wire logic [KC_W-1:0]            req_entry_kc,
   input  wire logic signed [STAGE_W-1:0]  req_stage,
   input  wire logic                       req_before_sowing,
   input  wire logic                       req_after_harvest,
   // result output
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [KC_W-1:0]                 rsp_kc,
   output logic [1:0]                      rsp_source,
   // csr port
   input  wire logic                       csr_wen,
   input  wire logic [CSR_IDX_W-1:0]       csr_index,
   input  wire logic [KC_W-1:0]            csr_wdata
);

   // csr registers
   logic [KC_W-1:0]     bare_kc_ff;
   logic [KC_W-1:0]     post_kc_ff;
   logic [PCOUNT_W-1:0] pcount_ff;
   logic [CNT_W-1:0]    n_eff;

   // working registers
   logic signed [STAGE_W-1:0] s_ff;
   logic                      sow_ff;
   logic                      harv_ff;
   logic [CNT_W-1:0]          idx_ff;
   logic [CNT_W-1:0]          idx_in;
   logic [CNT_W-1:0]          idx_nx;
   logic signed [STAGE_W-1:0] x1_ff;
   logic [KC_W-1:0]           y1_ff;
   logic [KC_W-1:0]           y0_ff;
   logic                      below_ff;
   logic [STAGE_W-1:0]        d_ff;
   logic [STAGE_W-1:0]        ofs_ff;
   logic [KC_W-1:0]           dymag_ff;
   logic                      neg_ff;
   logic [PROD_W-1:0]         prod_ff;
   logic [KC_W-1:0]           rem_ff;
   logic [KC_W-1:0]           quo_ff;
   logic [DIV_CNT_W-1:0]      cnt_ff;
   logic [KC_W-1:0]           res_kc_ff;
   src_type                   res_src_ff;
   logic                      rsp_valid_ff;
   logic [KC_W-1:0]           rsp_kc_ff;
   src_type                   rsp_src_ff;

   // table port
   logic                      tbl_wr_en;
   logic [ENTRY_W-1:0]        tbl_rd_data;
   logic signed [STAGE_W-1:0] rd_x;
   logic [KC_W-1:0]           rd_y;

   // combinational helpers
   logic                      accept;
   logic                      is_bare;
   logic                      is_post;
   logic                      seg_match;
   logic signed [STAGE_W:0]   dx_wide;
   logic signed [STAGE_W:0]   ofs_wide;
   logic signed [KC_W:0]      dy_wide;
   logic [KC_W:0]             dy_abs;
   logic [PROD_W:0]           dividend;
   logic [KC_W:0]             div_trial;
   logic                      div_ge;
   logic [KC_W:0]             div_sub;
   logic [KC_W:0]             kc_sum;
   logic                      out_free;

   // effective breakpoint count, clamped to the table
   always_comb begin
      if (pcount_ff < PCOUNT_W'(2)) begin
         n_eff = CNT_W'(2);
      end else if (32'(pcount_ff) > TABLE_DEPTH) begin
         n_eff = CNT_W'(TABLE_DEPTH);
      end else begin
         n_eff = CNT_W'(pcount_ff);
      end
   end

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         bare_kc_ff <= KC_W'(2458);
         post_kc_ff <= KC_W'(2458);
         pcount_ff  <= PCOUNT_W'(2);
      end else if (csr_wen) begin
         case (csr_index)
            CSR_BARE_KC:     bare_kc_ff <= csr_wdata;
            CSR_POST_KC:     post_kc_ff <= csr_wdata;
            CSR_POINT_COUNT: pcount_ff  <= csr_wdata[PCOUNT_W-1:0];
            default:         ;
         endcase
      end
   end

   // input handshake
   assign req_ready = (op == OP_LATCH);
   assign accept    = req_valid && req_ready;
   assign tbl_wr_en = accept && (req_opcode == OPC_LOAD) &&
                      (32'(req_entry_index) < TABLE_DEPTH);

   // breakpoint table, addressed one step ahead so data is ready next cycle
   skci_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (IDX_W'(req_entry_index)),
      .wr_data ({req_entry_stage, req_entry_kc}),
      .rd_addr (idx_in[IDX_W-1:0]),
      .rd_data (tbl_rd_data)
   );

   assign rd_x = $signed(tbl_rd_data[ENTRY_W-1:KC_W]);
   assign rd_y = tbl_rd_data[KC_W-1:0];

   // segment test and segment geometry
   always_comb begin
      is_bare   = sow_ff || (s_ff <= 0);
      is_post   = harv_ff || (s_ff >= STAGE_TWO);
      seg_match = (s_ff >= x1_ff) && (s_ff < rd_x);
      idx_nx    = idx_ff + CNT_W'(1);
      dx_wide   = {rd_x[STAGE_W-1], rd_x} - {x1_ff[STAGE_W-1], x1_ff};
      ofs_wide  = {s_ff[STAGE_W-1], s_ff} - {x1_ff[STAGE_W-1], x1_ff};
      dy_wide   = $signed({1'b0, rd_y}) - $signed({1'b0, y1_ff});
      dy_abs    = dy_wide[KC_W] ? (~dy_wide + 1'b1) : dy_wide;
   end

   // divider step and final sum
   always_comb begin
      dividend  = {1'b0, prod_ff} + (PROD_W + 1)'(d_ff >> 1);
      div_trial = {rem_ff, quo_ff[KC_W-1]};
      div_ge    = (div_trial >= {1'b0, d_ff});
      div_sub   = div_trial - {1'b0, d_ff};
      kc_sum    = neg_ff ? ({1'b0, y1_ff} - {1'b0, quo_ff})
                         : ({1'b0, y1_ff} + {1'b0, quo_ff});
   end

   // scan index
   always_comb begin
      idx_in = idx_ff;
      if (op == OP_LATCH) begin
         idx_in = '0;
      end else if (op == OP_FIRST) begin
         idx_in = idx_nx;
      end else if ((op == OP_SCAN) && !seg_match) begin
         idx_in = idx_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   // working payload registers, driven by the current control word
   always_ff @(posedge clock) begin
      case (op)
         OP_LATCH: begin
            s_ff    <= req_stage;
            sow_ff  <= req_before_sowing;
            harv_ff <= req_after_harvest;
         end
         OP_FIRST: begin
            x1_ff    <= rd_x;
            y1_ff    <= rd_y;
            y0_ff    <= rd_y;
            below_ff <= (s_ff < rd_x);
            res_kc_ff  <= is_bare ? bare_kc_ff : post_kc_ff;
            res_src_ff <= is_bare ? SRC_BARE : SRC_POST;
         end
         OP_SCAN: begin
            if (seg_match) begin
               d_ff     <= dx_wide[STAGE_W-1:0];
               ofs_ff   <= ofs_wide[STAGE_W-1:0];
               dymag_ff <= dy_abs[KC_W-1:0];
               neg_ff   <= dy_wide[KC_W];
            end else begin
               x1_ff <= rd_x;
               y1_ff <= rd_y;
            end
         end
         OP_NOMATCH: begin
            res_kc_ff  <= below_ff ? y0_ff : y1_ff;
            res_src_ff <= SRC_CLAMP;
         end
         OP_MUL: begin
            prod_ff <= dymag_ff * ofs_ff;
         end
         OP_PREP: begin
            // upper half stays below the divisor, so sixteen steps suffice
            rem_ff <= dividend[PROD_W-1:KC_W];
            quo_ff <= dividend[KC_W-1:0];
            cnt_ff <= '0;
         end
         OP_DIV: begin
            rem_ff <= div_ge ? div_sub[KC_W-1:0] : div_trial[KC_W-1:0];
            quo_ff <= {quo_ff[KC_W-2:0], div_ge};
            cnt_ff <= cnt_ff + DIV_CNT_W'(1);
         end
         OP_FINISH: begin
            res_kc_ff  <= kc_sum[KC_W-1:0];
            res_src_ff <= SRC_INTERP;
         end
         default: ;
      endcase
   end

   // output register
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((op == OP_EMIT) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((op == OP_EMIT) && out_free) begin
         rsp_kc_ff  <= res_kc_ff;
         rsp_src_ff <= res_src_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_kc     = rsp_kc_ff;
   assign rsp_source = rsp_src_ff;

   // status back to the sequencer
   always_comb begin
      status.eval_accept = accept && (req_opcode == OPC_EVAL);
      status.special     = is_bare || is_post;
      status.match       = seg_match;
      status.more        = (idx_nx < n_eff);
      status.div_more    = (cnt_ff != DIV_CNT_W'(DIV_STEPS - 1));
      status.out_free    = out_free;
   end

endmodule

`default_nettype wire

### sv/stage_kc_interpolator_top.sv
// top level of the stage dependent crop coefficient interpolator
//
//  channel  ports   direction  carries
//  req      req_*   in         load of one breakpoint, or evaluate of one stage
//  rsp      rsp_*   out        crop coefficient and its source, one per evaluate
//  csr      csr_*   in         bare soil kc, post harvest kc, point count
//
// a load is taken in the idle step; the block is ready again in the next cycle.
// an evaluate of bare soil or post harvest goes from the first step straight to emit.
// an interpolating evaluate scans k segments, k at most one less than the point
// count clamped to 2..16, with one table read per segment, then multiplies and
// takes sixteen divider steps before it finishes and emits.
// reset is synchronous; the table holds no defined values until loaded.
// one item is worked at a time; a stalled result waits in the output register
// while the next item is taken and worked up to its final step.
`default_nettype none

module stage_kc_interpolator_top
   import skci_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   // request channel
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic                       req_opcode,
   input  wire logic [3:0]                 req_entry_index,
   input  wire logic signed [STAGE_W-1:0]  req_entry_stage,
   input  wire logic [KC_W-1:0]            req_entry_kc,
   input  wire logic signed [STAGE_W-1:0]  req_stage,
   input  wire logic                       req_before_sowing,
   input  wire logic                       req_after_harvest,
   // response channel
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [KC_W-1:0]                 rsp_kc,
   output logic [1:0]                      rsp_source,
   // csr write port
   input  wire logic                       csr_wen,
   input  wire logic [CSR_IDX_W-1:0]       csr_index,
   input  wire logic [KC_W-1:0]            csr_wdata
);

   op_type     op;
   status_type status;

   // control program
   skci_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .op     (op)
   );

   // datapath
   skci_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .op                (op),
      .status            (status),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_entry_index   (req_entry_index),
      .req_entry_stage   (req_entry_stage),
      .req_entry_kc      (req_entry_kc),
      .req_stage         (req_stage),
      .req_before_sowing (req_before_sowing),
      .req_after_harvest (req_after_harvest),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kc            (rsp_kc),
      .rsp_source        (rsp_source),
      .csr_wen           (csr_wen),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

endmodule

`default_nettype wire

### sv/skci_checker.sv
// port level checker for the interpolator top, with its bind
`default_nettype none

module skci_checker
   import skci_pkg::*;
(
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_ready,
   input wire logic                       req_opcode,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic [KC_W-1:0]            rsp_kc,
   input wire logic [1:0]                 rsp_source
);

   // no result survives reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_kc) && $stable(rsp_source)))
      else $error("stalled response changed");

   // an evaluate transaction leaves the block not ready in the next cycle
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_opcode == OPC_EVAL)) |=> !req_ready)
      else $error("ready straight after an evaluate");

   // the block is ready again in the cycle after a table load
   a_load_quick: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_opcode == OPC_LOAD)) |=> req_ready)
      else $error("not ready after a load");

endmodule

bind stage_kc_interpolator_top skci_checker u_skci_checker (.*);

`default_nettype wire

### tb/stage_kc_interpolator_top_tb.sv
// self-checking testbench of the stage kc interpolator: directed and random transactions
`default_nettype none

module stage_kc_interpolator_top_tb
   import skci_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES   = 64;
   localparam int ITEMS_PER_PHASE = 75;
   localparam int RANDOM_PHASES   = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   // one request transaction, every field as on the port
   typedef struct {
      logic                      opcode;
      logic [3:0]                entry_index;
      logic signed [STAGE_W-1:0] entry_stage;
      logic [KC_W-1:0]           entry_kc;
      logic signed [STAGE_W-1:0] stage;
      logic                      before_sowing;
      logic                      after_harvest;
   } req_type;

   // one response transaction
   typedef struct {
      logic [KC_W-1:0] kc;
      src_type         source;
   } kc_result_type;

   // breakpoint table mirror, coefficient predictor and result check
   class kc_scoreboard_type;
      logic signed [STAGE_W-1:0] bp_stage [TABLE_DEPTH];
      logic [KC_W-1:0]           bp_kc [TABLE_DEPTH];
      logic [KC_W-1:0]           bare_kc;
      logic [KC_W-1:0]           post_kc;
      logic [PCOUNT_W-1:0]       point_count;
      kc_result_type             pending_kc [$];
      int                        mismatches;

      function new();
         bare_kc     = 16'd2458;
         post_kc     = 16'd2458;
         point_count = 5'd2;
         mismatches  = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [KC_W-1:0] data);
         case (idx)
            CSR_BARE_KC:     bare_kc = data;
            CSR_POST_KC:     post_kc = data;
            CSR_POINT_COUNT: point_count = data[PCOUNT_W-1:0];
            default: ;
         endcase
      endfunction

      // segment search and rounded linear interpolation
      function kc_result_type interpolate_kc(longint s);
         kc_result_type r;
         int            n;
         longint        x1, x2, y1, y2, d, num, mag, q, v;
         bit            found;
         n = int'(point_count);
         if (n < 2) n = 2;
         if (n > TABLE_DEPTH) n = TABLE_DEPTH;
         found    = 1'b0;
         r.source = SRC_CLAMP;
         r.kc     = '0;
         for (int i = 0; i + 1 < n && !found; i++) begin
            x1 = longint'(bp_stage[i]);
            x2 = longint'(bp_stage[i+1]);
            if (s >= x1 && s < x2) begin
               y1  = longint'(bp_kc[i]);
               y2  = longint'(bp_kc[i+1]);
               d   = x2 - x1;
               num = (y2 - y1) * (s - x1);
               mag = (num < 0) ? -num : num;
               q   = (mag + d / 2) / d;
               if (num < 0) q = -q;
               v = y1 + q;
               if (v < 0) v = 0;
               if (v > 65535) v = 65535;
               r.kc     = v[KC_W-1:0];
               r.source = SRC_INTERP;
               found    = 1'b1;
            end
         end
         // outside the table: clamp to the first or the last valid point
         if (!found)
            r.kc = (s < longint'(bp_stage[0])) ? bp_kc[0] : bp_kc[n-1];
         return r;
      endfunction

      function kc_result_type predict_kc(req_type r);
         kc_result_type e;
         longint        s;
         s = longint'(r.stage);
         if (r.before_sowing || s <= 0) begin
            e.kc     = bare_kc;
            e.source = SRC_BARE;
         end else if (r.after_harvest || s >= longint'(STAGE_TWO)) begin
            e.kc     = post_kc;
            e.source = SRC_POST;
         end else begin
            e = interpolate_kc(s);
         end
         return e;
      endfunction

      function void note_request(req_type r);
         if (r.opcode == OPC_LOAD) begin
            bp_stage[r.entry_index] = r.entry_stage;
            bp_kc[r.entry_index]    = r.entry_kc;
         end else begin
            pending_kc.push_back(predict_kc(r));
         end
      endfunction

      task report_mismatch(string what);
         $display("MISMATCH at %0t ns: %s", $time, what);
         mismatches++;
      endtask

      task check_response(logic [KC_W-1:0] kc, logic [1:0] source);
         kc_result_type e;
         if (pending_kc.size() == 0) begin
            report_mismatch($sformatf("result kc=%0d source=%0d with none outstanding",
                                      kc, source));
            return;
         end
         e = pending_kc.pop_front();
         if (kc !== e.kc)
            report_mismatch($sformatf("kc %0d, expected %0d (source %s)",
                                      kc, e.kc, e.source.name()));
         if (source !== e.source)
            report_mismatch($sformatf("source %0d, expected %s (kc %0d)",
                                      source, e.source.name(), e.kc));
      endtask

      task flush_check();
         if (pending_kc.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_kc.size()));
      endtask
   endclass

   // block ports
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_opcode = 1'b0;
   logic [3:0]                req_entry_index = '0;
   logic signed [STAGE_W-1:0] req_entry_stage = '0;
   logic [KC_W-1:0]           req_entry_kc = '0;
   logic signed [STAGE_W-1:0] req_stage = '0;
   logic                      req_before_sowing = 1'b0;
   logic                      req_after_harvest = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [KC_W-1:0]           rsp_kc;
   logic [1:0]                rsp_source;
   logic                      csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [KC_W-1:0]           csr_wdata = '0;

   int                send_idle_pct  = 0;
   int                recv_stall_pct = 0;
   kc_scoreboard_type kc_sb = new();

   stage_kc_interpolator_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_entry_index   (req_entry_index),
      .req_entry_stage   (req_entry_stage),
      .req_entry_kc      (req_entry_kc),
      .req_stage         (req_stage),
      .req_before_sowing (req_before_sowing),
      .req_after_harvest (req_after_harvest),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kc            (rsp_kc),
      .rsp_source        (rsp_source),
      .csr_wen           (csr_wen),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // response side: check the accepted transaction, then pick the next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         kc_sb.check_response(rsp_kc, rsp_source);
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   function automatic int rand_stage();
      return int'($urandom_range(0, 24576)) - 8192;
   endfunction

   function automatic int rand_kc();
      case ($urandom_range(0, 7))
         0:       return 0;
         1:       return 65535;
         default: return int'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic int rand_eval_stage();
      case ($urandom_range(0, 9))
         8:       return rand_stage();
         9: begin
            case ($urandom_range(0, 5))
               0:       return -8192;
               1:       return -1;
               2:       return 0;
               3:       return 1;
               4:       return 16383;
               default: return 16384;
            endcase
         end
         default: return int'($urandom_range(1, 16383));
      endcase
   endfunction

   // unused fields carry random junk so that every port bit toggles
   function automatic req_type load_req(int idx, int stg, int kc);
      req_type r;
      r.opcode        = OPC_LOAD;
      r.entry_index   = 4'(idx);
      r.entry_stage   = 16'(stg);
      r.entry_kc      = 16'(kc);
      r.stage         = 16'($urandom);
      r.before_sowing = 1'($urandom);
      r.after_harvest = 1'($urandom);
      return r;
   endfunction

   function automatic req_type eval_req(int stg, bit sow, bit harv);
      req_type r;
      r.opcode        = OPC_EVAL;
      r.entry_index   = 4'($urandom);
      r.entry_stage   = 16'($urandom);
      r.entry_kc      = 16'($urandom);
      r.stage         = 16'(stg);
      r.before_sowing = sow;
      r.after_harvest = harv;
      return r;
   endfunction

   // drive one request; valid stays high after acceptance unless the caller drops it
   task automatic send_req(input req_type r);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_opcode        <= r.opcode;
      req_entry_index   <= r.entry_index;
      req_entry_stage   <= r.entry_stage;
      req_entry_kc      <= r.entry_kc;
      req_stage         <= r.stage;
      req_before_sowing <= r.before_sowing;
      req_after_harvest <= r.after_harvest;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      kc_sb.note_request(r);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [KC_W-1:0] data);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      kc_sb.write_reg(idx, data);
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   // drain outstanding results, then let any trailing load finish
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (kc_sb.pending_kc.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // load slots 0..n-1, mostly in rising stage order
   task automatic load_breakpoints(input int n, input bit ordered);
      int x;
      int span;
      x    = ($urandom_range(0, 3) == 0) ? rand_stage() : int'($urandom_range(0, 4000));
      span = (16384 - x) * 2 / (n - 1);
      for (int i = 0; i < n; i++) begin
         if (!ordered) x = rand_stage();
         send_req(load_req(i, x, rand_kc()));
         if (ordered) begin
            x += ($urandom_range(0, 15) == 0) ? 0 : int'($urandom_range(1, span + 1));
            if (x > 16384) x = 16384;
         end
      end
   endtask

   // stimulus
   initial begin
      int pcount;
      int n_eff;
      int bare;
      int post;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: register extremes, an ignored index, a four point table
      write_csr(CSR_BARE_KC, 16'hFFFF);
      write_csr(CSR_POST_KC, 16'h0000);
      write_csr(CSR_POINT_COUNT, 16'd4);
      write_csr(CSR_UNUSED, 16'h5A5A);
      send_req(load_req(0, -8192, 0));
      send_req(load_req(1, 4096, 65535));
      send_req(load_req(2, 8192, 100));
      send_req(load_req(3, 16384, 65535));
      // stage limits, breakpoint hits, rising and falling segments
      send_req(eval_req(-8192, 1'b0, 1'b0));
      send_req(eval_req(0, 1'b0, 1'b0));
      send_req(eval_req(1, 1'b0, 1'b0));
      send_req(eval_req(4095, 1'b0, 1'b0));
      send_req(eval_req(4096, 1'b0, 1'b0));
      send_req(eval_req(6000, 1'b0, 1'b0));
      send_req(eval_req(16383, 1'b0, 1'b0));
      send_req(eval_req(16384, 1'b0, 1'b0));
      // date flags, bare soil wins when both are set
      send_req(eval_req(5000, 1'b1, 1'b0));
      send_req(eval_req(5000, 1'b0, 1'b1));
      send_req(eval_req(5000, 1'b1, 1'b1));
      send_req(eval_req(-1, 1'b0, 1'b1));
      // shrink the table span: stages below the first and past the last point clamp
      send_req(load_req(0, 2000, 30000));
      send_req(load_req(3, 12000, 7));
      send_req(eval_req(1000, 1'b0, 1'b0));
      send_req(eval_req(14000, 1'b0, 1'b0));
      send_req(eval_req(2000, 1'b0, 1'b0));
      settle();

      // random phases, each with its own settings and idling pattern
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p % 4)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 63; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 63; end
            default: begin send_idle_pct = 34; recv_stall_pct = 34; end
         endcase
         case (p)
            0:       pcount = 16;
            1:       pcount = 2;
            2:       pcount = 0;
            3:       pcount = 31;
            4:       pcount = 9;
            5:       pcount = 17;
            6:       pcount = 1;
            default: pcount = 5;
         endcase
         bare = (p == 1) ? 0 : (p == 2) ? 65535 : int'($urandom_range(0, 65535));
         post = (p == 1) ? 65535 : (p == 2) ? 0 : int'($urandom_range(0, 65535));
         write_csr(CSR_BARE_KC, 16'(bare));
         write_csr(CSR_POST_KC, 16'(post));
         write_csr(CSR_POINT_COUNT, 16'(pcount));
         write_csr(CSR_UNUSED, 16'($urandom));
         n_eff = (pcount < 2) ? 2 : (pcount > TABLE_DEPTH) ? TABLE_DEPTH : pcount;
         load_breakpoints(n_eff, $urandom_range(0, 4) != 0);
         // mostly evaluations, with the odd stray load that may break the order
         for (int k = 0; k < ITEMS_PER_PHASE - n_eff; k++) begin
            if ($urandom_range(0, 19) == 0)
               send_req(load_req(int'($urandom_range(0, 15)), rand_stage(), rand_kc()));
            else
               send_req(eval_req(rand_eval_stage(), $urandom_range(0, 9) == 0,
                                 $urandom_range(0, 9) == 0));
         end
         settle();
      end

      kc_sb.flush_check();
      if (kc_sb.mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire
